// ----- rtl/nps_pkg.sv -----
// Shared types, constants and cell lookup functions for the nine-patch slicer.
package nps_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned CFG_W  = 15;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned OUT_W  = 18;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned NCELL  = 9;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_SRC_LEFT   = 3'd0;
  localparam logic [IDX_W-1:0] REG_SRC_TOP    = 3'd1;
  localparam logic [IDX_W-1:0] REG_SRC_RIGHT  = 3'd2;
  localparam logic [IDX_W-1:0] REG_SRC_BOTTOM = 3'd3;
  localparam logic [IDX_W-1:0] REG_MRG_LEFT   = 3'd4;
  localparam logic [IDX_W-1:0] REG_MRG_TOP    = 3'd5;
  localparam logic [IDX_W-1:0] REG_MRG_RIGHT  = 3'd6;
  localparam logic [IDX_W-1:0] REG_MRG_BOTTOM = 3'd7;

  // Draw and expand mode codes.
  localparam logic [MODE_W-1:0] MODE_NONE    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STRETCH = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TILE    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNUSED  = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;
    logic       calc;
    logic       clip;
    logic       load_out;
    logic       bad;
    logic [1:0] col;
    logic [1:0] row;
    logic       last;
  } nps_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       invalid;
    logic [2:0] col_nz;
    logic [2:0] row_nz;
  } nps_stat_t;

  // Column of a cell in row-major order.
  function automatic logic [1:0] nps_cell_col(input logic [3:0] idx);
    logic [1:0] c;
    case (idx)
      4'd0, 4'd3, 4'd6: c = 2'd0;
      4'd1, 4'd4, 4'd7: c = 2'd1;
      4'd2, 4'd5, 4'd8: c = 2'd2;
      default:          c = 2'd0;
    endcase
    return c;
  endfunction

  // Row of a cell in row-major order.
  function automatic logic [1:0] nps_cell_row(input logic [3:0] idx);
    logic [1:0] r;
    case (idx)
      4'd0, 4'd1, 4'd2: r = 2'd0;
      4'd3, 4'd4, 4'd5: r = 2'd1;
      4'd6, 4'd7, 4'd8: r = 2'd2;
      default:          r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/nps_ctrl.sv -----
// Controller state machine: sequences boundary setup and walks the non-empty cells.
module nps_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  input  nps_pkg::nps_stat_t stat_i,
  output nps_pkg::nps_cmd_t  cmd_o
);
  import nps_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CALC = 3'd1;
  localparam logic [2:0] S_CLIP = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;
  localparam logic [2:0] S_BAD  = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [NCELL-1:0] pend_q, pend_d;
  logic             out_valid_q, out_valid_d;
  logic [NCELL-1:0] mask;
  logic [NCELL-1:0] pend_rest;
  logic [3:0]       idx;
  logic             slot_free;

  // Cells with non-zero source width and height.
  always_comb begin
    for (int y = 0; y < 3; y++) begin
      for (int x = 0; x < 3; x++) begin
        mask[y*3+x] = stat_i.row_nz[y] & stat_i.col_nz[x];
      end
    end
  end

  // Lowest pending cell, and the pending set without it.
  always_comb begin
    idx = 4'd0;
    for (int i = NCELL - 1; i >= 0; i--) begin
      if (pend_q[i]) begin
        idx = 4'(i);
      end
    end
  end

  assign pend_rest = pend_q & (pend_q - NCELL'(1));
  assign slot_free = !out_valid_q || out_ready_i;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    pend_d  = pend_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_CALC;
        end
      end
      S_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = S_CLIP;
      end
      S_CLIP: begin
        cmd_o.clip = 1'b1;
        state_d    = S_SCAN;
      end
      S_SCAN: begin
        if (stat_i.invalid) begin
          state_d = S_BAD;
        end else begin
          pend_d  = mask;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (pend_q == '0) begin
          state_d = S_IDLE;
        end else if (slot_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.col      = nps_cell_col(idx);
          cmd_o.row      = nps_cell_row(idx);
          cmd_o.last     = (pend_rest == '0);
          pend_d         = pend_rest;
          if (pend_rest == '0) begin
            state_d = S_IDLE;
          end
        end
      end
      S_BAD: begin
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.bad      = 1'b1;
          cmd_o.last     = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output request valid: set on load, cleared when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/nps_dp.sv -----
// Datapath: configuration registers, boundary arithmetic, clipping and the result register.
module nps_dp #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [nps_pkg::IDX_W-1:0]            cfg_idx_i,
  input  logic [nps_pkg::CFG_W-1:0]            cfg_data_i,
  input  logic signed [COORD_BITS-1:0]         dest_left_i,
  input  logic signed [COORD_BITS-1:0]         dest_top_i,
  input  logic signed [COORD_BITS-1:0]         dest_right_i,
  input  logic signed [COORD_BITS-1:0]         dest_bottom_i,
  input  logic [nps_pkg::MODE_W-1:0]           expand_mode_i,
  input  nps_pkg::nps_cmd_t                    cmd_i,
  output nps_pkg::nps_stat_t                   stat_o,
  output logic                                 status_o,
  output logic signed [nps_pkg::OUT_W-1:0]     cell_src_left_o,
  output logic signed [nps_pkg::OUT_W-1:0]     cell_src_top_o,
  output logic signed [nps_pkg::OUT_W-1:0]     cell_src_right_o,
  output logic signed [nps_pkg::OUT_W-1:0]     cell_src_bottom_o,
  output logic signed [nps_pkg::OUT_W-1:0]     cell_dst_left_o,
  output logic signed [nps_pkg::OUT_W-1:0]     cell_dst_top_o,
  output logic signed [nps_pkg::OUT_W-1:0]     cell_dst_right_o,
  output logic signed [nps_pkg::OUT_W-1:0]     cell_dst_bottom_o,
  output logic [nps_pkg::MODE_W-1:0]           cell_mode_o,
  output logic                                 last_cell_o
);
  import nps_pkg::*;

  // Internal width covers coordinates, margins and their sums and differences.
  localparam int unsigned BASE_W = (COORD_BITS > 16) ? COORD_BITS : 16;
  localparam int unsigned IW     = BASE_W + 4;

  logic [CFG_W-1:0] cfg_q [8];

  logic signed [IW-1:0] dl_q, dt_q, dr_q, db_q;
  logic [MODE_W-1:0]    mode_q;

  logic signed [IW-1:0] sl, st, sr, sb, ml, mt, mr, mb;

  logic signed [IW-1:0] dx1_q, dx2_q, sx1_q, sx2_q, szx_q, spx_q;
  logic signed [IW-1:0] dy1_q, dy2_q, sy1_q, sy2_q, szy_q, spy_q;
  logic [CFG_W:0]       smx_q, smy_q;
  logic                 invalid_q;

  logic signed [IW-1:0] dx1_d, dx2_d, sx1_d, sx2_d, szx_d, spx_d;
  logic signed [IW-1:0] dy1_d, dy2_d, sy1_d, sy2_d, szy_d, spy_d;

  logic signed [IW-1:0] sxb_q [4];
  logic signed [IW-1:0] dxb_q [4];
  logic signed [IW-1:0] syb_q [4];
  logic signed [IW-1:0] dyb_q [4];
  logic signed [IW-1:0] sxb_d [4];
  logic signed [IW-1:0] dxb_d [4];
  logic signed [IW-1:0] syb_d [4];
  logic signed [IW-1:0] dyb_d [4];

  logic [1:0] col_n, row_n;

  // Fit the margins of one axis to the destination size.
  function automatic logic [8*IW-1:0] clip_axis(
    input logic signed [IW-1:0] s0, s1, s2, s3,
    input logic signed [IW-1:0] d0, d1, d2, d3,
    input logic signed [IW-1:0] size, spx,
    input logic [CFG_W-1:0]     m0, m1,
    input logic [CFG_W:0]       sum
  );
    logic signed [IW-1:0] n0, n1, n2, n3, e0, e1, e2, e3;
    logic signed [IW-1:0] m0e, m1e, sume, s0p, s3m, spm;
    m0e  = signed'({{(IW-CFG_W){1'b0}}, m0});
    m1e  = signed'({{(IW-CFG_W){1'b0}}, m1});
    sume = signed'({{(IW-CFG_W-1){1'b0}}, sum});
    s0p  = s0 + size;
    s3m  = s3 - size;
    spm  = spx - size;
    n0 = s0; n1 = s1; n2 = s2; n3 = s3;
    e0 = d0; e1 = d1; e2 = d2; e3 = d3;
    if (sume <= size) begin
      n0 = s0;
    end else if (m0e >= size) begin
      // Left or top border alone covers the destination.
      n1 = s0p; n2 = s0p; n3 = s0p;
      e1 = d3;  e2 = d3;  e3 = d3;
    end else if (m1e >= size) begin
      // Right or bottom border alone covers the destination.
      n0 = s3m; n1 = s3m; n2 = s3m;
      e0 = d0;  e1 = d0;  e2 = d0;
    end else begin
      // First border kept whole, second one fills the rest.
      n2 = spm;
      e2 = d1;
    end
    return {n0, n1, n2, n3, e0, e1, e2, e3};
  endfunction

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        cfg_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  assign sl = signed'({{(IW-CFG_W){1'b0}}, cfg_q[REG_SRC_LEFT]});
  assign st = signed'({{(IW-CFG_W){1'b0}}, cfg_q[REG_SRC_TOP]});
  assign sr = signed'({{(IW-CFG_W){1'b0}}, cfg_q[REG_SRC_RIGHT]});
  assign sb = signed'({{(IW-CFG_W){1'b0}}, cfg_q[REG_SRC_BOTTOM]});
  assign ml = signed'({{(IW-CFG_W){1'b0}}, cfg_q[REG_MRG_LEFT]});
  assign mt = signed'({{(IW-CFG_W){1'b0}}, cfg_q[REG_MRG_TOP]});
  assign mr = signed'({{(IW-CFG_W){1'b0}}, cfg_q[REG_MRG_RIGHT]});
  assign mb = signed'({{(IW-CFG_W){1'b0}}, cfg_q[REG_MRG_BOTTOM]});

  // Capture the request; the unused mode code reads as none.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      dl_q   <= signed'({{(IW-COORD_BITS){dest_left_i[COORD_BITS-1]}}, dest_left_i});
      dt_q   <= signed'({{(IW-COORD_BITS){dest_top_i[COORD_BITS-1]}}, dest_top_i});
      dr_q   <= signed'({{(IW-COORD_BITS){dest_right_i[COORD_BITS-1]}}, dest_right_i});
      db_q   <= signed'({{(IW-COORD_BITS){dest_bottom_i[COORD_BITS-1]}}, dest_bottom_i});
      mode_q <= (expand_mode_i == MODE_UNUSED) ? MODE_NONE : expand_mode_i;
    end
  end

  // Raw inner boundaries, sizes and the pre-summed source term for the shared case.
  always_comb begin
    dx1_d = dl_q + ml;
    dx2_d = dr_q - mr;
    sx1_d = sl + ml;
    sx2_d = sr - mr;
    szx_d = dr_q - dl_q;
    spx_d = sr + ml;
    dy1_d = dt_q + mt;
    dy2_d = db_q - mb;
    sy1_d = st + mt;
    sy2_d = sb - mb;
    szy_d = db_q - dt_q;
    spy_d = sb + mt;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      dx1_q     <= dx1_d;
      dx2_q     <= dx2_d;
      sx1_q     <= sx1_d;
      sx2_q     <= sx2_d;
      szx_q     <= szx_d;
      spx_q     <= spx_d;
      smx_q     <= {1'b0, cfg_q[REG_MRG_LEFT]} + {1'b0, cfg_q[REG_MRG_RIGHT]};
      dy1_q     <= dy1_d;
      dy2_q     <= dy2_d;
      sy1_q     <= sy1_d;
      sy2_q     <= sy2_d;
      szy_q     <= szy_d;
      spy_q     <= spy_d;
      smy_q     <= {1'b0, cfg_q[REG_MRG_TOP]} + {1'b0, cfg_q[REG_MRG_BOTTOM]};
      // The source split is monotone unless the inner boundaries cross.
      invalid_q <= (sx1_d > sx2_d) || (sy1_d > sy2_d);
    end
  end

  // Clipped boundaries for both axes.
  always_comb begin
    {sxb_d[0], sxb_d[1], sxb_d[2], sxb_d[3], dxb_d[0], dxb_d[1], dxb_d[2], dxb_d[3]} =
      clip_axis(sl, sx1_q, sx2_q, sr, dl_q, dx1_q, dx2_q, dr_q, szx_q, spx_q,
                cfg_q[REG_MRG_LEFT], cfg_q[REG_MRG_RIGHT], smx_q);
    {syb_d[0], syb_d[1], syb_d[2], syb_d[3], dyb_d[0], dyb_d[1], dyb_d[2], dyb_d[3]} =
      clip_axis(st, sy1_q, sy2_q, sb, dt_q, dy1_q, dy2_q, db_q, szy_q, spy_q,
                cfg_q[REG_MRG_TOP], cfg_q[REG_MRG_BOTTOM], smy_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clip) begin
      for (int i = 0; i < 4; i++) begin
        sxb_q[i] <= sxb_d[i];
        dxb_q[i] <= dxb_d[i];
        syb_q[i] <= syb_d[i];
        dyb_q[i] <= dyb_d[i];
      end
    end
  end

  // Columns and rows of non-zero source size.
  always_comb begin
    stat_o.invalid = invalid_q;
    for (int i = 0; i < 3; i++) begin
      stat_o.col_nz[i] = (sxb_q[i] != sxb_q[i+1]);
      stat_o.row_nz[i] = (syb_q[i] != syb_q[i+1]);
    end
  end

  assign col_n = cmd_i.col + 2'd1;
  assign row_n = cmd_i.row + 2'd1;

  // Result register: one cell, or the invalid-split marker.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      last_cell_o <= cmd_i.last;
      if (cmd_i.bad) begin
        status_o          <= 1'b1;
        cell_src_left_o   <= '0;
        cell_src_top_o    <= '0;
        cell_src_right_o  <= '0;
        cell_src_bottom_o <= '0;
        cell_dst_left_o   <= '0;
        cell_dst_top_o    <= '0;
        cell_dst_right_o  <= '0;
        cell_dst_bottom_o <= '0;
        cell_mode_o       <= MODE_NONE;
      end else begin
        status_o          <= 1'b0;
        cell_src_left_o   <= sxb_q[cmd_i.col][OUT_W-1:0];
        cell_src_top_o    <= syb_q[cmd_i.row][OUT_W-1:0];
        cell_src_right_o  <= sxb_q[col_n][OUT_W-1:0];
        cell_src_bottom_o <= syb_q[row_n][OUT_W-1:0];
        cell_dst_left_o   <= dxb_q[cmd_i.col][OUT_W-1:0];
        cell_dst_top_o    <= dyb_q[cmd_i.row][OUT_W-1:0];
        cell_dst_right_o  <= dxb_q[col_n][OUT_W-1:0];
        cell_dst_bottom_o <= dyb_q[row_n][OUT_W-1:0];
        // Corners are drawn unscaled; edges and center use the expand mode.
        cell_mode_o       <= (cmd_i.col == 2'd1 || cmd_i.row == 2'd1) ? mode_q : MODE_NONE;
      end
    end
  end

endmodule

// ----- rtl/nine_patch_slicer.sv -----
// Top level of the nine-patch slicer: controller, datapath and interface checks.
//
//   channel   direction  handshake                 payload
//   request   in         in_valid_i / in_ready_o   dest_*_i, expand_mode_i
//   result    out        out_valid_o / out_ready_i status_o, cell_*_o, last_cell_o
//   config    in         cfg_we_i                  cfg_idx_i, cfg_data_i
//
// A request steps through capture, boundary calculation, clipping and a scan of the
// cells, then loads one result per non-empty cell into the single result register,
// one cell per cycle while the result is not stalled (one result for an invalid split,
// none when every cell is empty).
// Reset clears the configuration registers, the controller and the result valid.
// A stalled result holds the cell walk; the next request is taken while the last
// result still waits.
module nine_patch_slicer #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [COORD_BITS-1:0]     dest_left_i,
  input  logic signed [COORD_BITS-1:0]     dest_top_i,
  input  logic signed [COORD_BITS-1:0]     dest_right_i,
  input  logic signed [COORD_BITS-1:0]     dest_bottom_i,
  input  logic [nps_pkg::MODE_W-1:0]       expand_mode_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             status_o,
  output logic signed [nps_pkg::OUT_W-1:0] cell_src_left_o,
  output logic signed [nps_pkg::OUT_W-1:0] cell_src_top_o,
  output logic signed [nps_pkg::OUT_W-1:0] cell_src_right_o,
  output logic signed [nps_pkg::OUT_W-1:0] cell_src_bottom_o,
  output logic signed [nps_pkg::OUT_W-1:0] cell_dst_left_o,
  output logic signed [nps_pkg::OUT_W-1:0] cell_dst_top_o,
  output logic signed [nps_pkg::OUT_W-1:0] cell_dst_right_o,
  output logic signed [nps_pkg::OUT_W-1:0] cell_dst_bottom_o,
  output logic [nps_pkg::MODE_W-1:0]       cell_mode_o,
  output logic                             last_cell_o,
  input  logic                             cfg_we_i,
  input  logic [nps_pkg::IDX_W-1:0]        cfg_idx_i,
  input  logic [nps_pkg::CFG_W-1:0]        cfg_data_i
);
  import nps_pkg::*;

  nps_cmd_t  cmd;
  nps_stat_t stat;

  // Sequencer.
  nps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Arithmetic and storage.
  nps_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .dest_left_i       (dest_left_i),
    .dest_top_i        (dest_top_i),
    .dest_right_i      (dest_right_i),
    .dest_bottom_i     (dest_bottom_i),
    .expand_mode_i     (expand_mode_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .status_o          (status_o),
    .cell_src_left_o   (cell_src_left_o),
    .cell_src_top_o    (cell_src_top_o),
    .cell_src_right_o  (cell_src_right_o),
    .cell_src_bottom_o (cell_src_bottom_o),
    .cell_dst_left_o   (cell_dst_left_o),
    .cell_dst_top_o    (cell_dst_top_o),
    .cell_dst_right_o  (cell_dst_right_o),
    .cell_dst_bottom_o (cell_dst_bottom_o),
    .cell_mode_o       (cell_mode_o),
    .last_cell_o       (last_cell_o)
  );

`ifndef SYNTH
  // An accepted request keeps the block busy for the setup cycles.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o ##1 !in_ready_o)
    else $error("request accepted during boundary setup");

  // An invalid split is a single result that closes the request.
  a_bad_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> last_cell_o && cell_mode_o == MODE_NONE)
    else $error("invalid split result not final or has a draw mode");

  // No result is loaded during the setup of a request.
  a_no_load_in_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.calc || cmd.clip || cmd.capture |-> !cmd.load_out)
    else $error("result loaded while boundaries are being built");
`endif

endmodule
